[sv/sprc_pkg.sv]
// ----------------------------------------------------------------------------
// sprc_pkg: shared types and constants of the seat pressure relief controller
// Holds the mode codes, register indexes, the configuration and result
// bundles, and the fixed limits of the pressure and timer logic.
// ----------------------------------------------------------------------------
package sprc_pkg;

  // Sample widths
  localparam int unsigned ForceW        = 10;
  localparam int unsigned PressW        = 10;
  localparam int unsigned TicksCfgW     = 17;
  localparam int unsigned ForceInputs   = 6;
  localparam int unsigned ForceChannels = 6;

  // Pressure clamp window in raw ADC counts
  localparam logic [PressW-1:0] PressLo = 10'd102;
  localparam logic [PressW-1:0] PressHi = 10'd921;

  // Relief and blink timers
  localparam int unsigned RelTimerW        = 6;
  localparam logic [RelTimerW-1:0] TimerMax = 6'd63;
  localparam logic [RelTimerW-1:0] VentTimeoutTicks = 6'd50;
  localparam int unsigned BlinkW           = 3;
  localparam logic [BlinkW-1:0] BlinkTicks = 3'd5;

  // Defaults of the top level parameters
  localparam int unsigned DefSitCountBits   = 17;
  localparam int unsigned DefTicksPerMinute = 600;

  // Output field width of the minute count
  localparam int unsigned MinutesW = 8;

  // Register reset values
  localparam logic [ForceW-1:0]    RstIdleLimit    = 10'd100;
  localparam logic [ForceW-1:0]    RstSitLimit     = 10'd273;
  localparam logic [TicksCfgW-1:0] RstWarnTicks    = 17'd72000;
  localparam logic [TicksCfgW-1:0] RstDangerTicks  = 17'd90000;
  localparam logic [PressW-1:0]    RstPumpOnBelow  = 10'd266;
  localparam logic [PressW-1:0]    RstPumpOffAt    = 10'd332;
  localparam logic [PressW-1:0]    RstVentDoneAt   = 10'd183;
  localparam logic [PressW-1:0]    RstRefillDoneAt = 10'd315;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeNormal  = 2'd1,
    ModeWarning = 2'd2,
    ModeDanger  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    RegIdleLimit    = 3'd0,
    RegSitLimit     = 3'd1,
    RegWarnTicks    = 3'd2,
    RegDangerTicks  = 3'd3,
    RegPumpOnBelow  = 3'd4,
    RegPumpOffAt    = 3'd5,
    RegVentDoneAt   = 3'd6,
    RegRefillDoneAt = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ForceW-1:0]    idle_limit;
    logic [ForceW-1:0]    sit_limit;
    logic [TicksCfgW-1:0] warn_ticks;
    logic [TicksCfgW-1:0] danger_ticks;
    logic [PressW-1:0]    pump_on_below;
    logic [PressW-1:0]    pump_off_at;
    logic [PressW-1:0]    vent_done_at;
    logic [PressW-1:0]    refill_done_at;
  } cfg_t;

  typedef struct packed {
    mode_e               mode;
    logic                pump_on;
    logic                valve_open;
    logic                buzzer_on;
    logic [ForceW-1:0]   peak_force;
    logic [MinutesW-1:0] sit_minutes;
    logic                relief_phase;
  } res_t;

endpackage

[sv/sprc_sample.sv]
// ----------------------------------------------------------------------------
// sprc_sample: force peak and pressure clamp
// Takes the largest of the active force channels and clamps the cushion
// pressure sample into its valid ADC window.
// ----------------------------------------------------------------------------
module sprc_sample (
  input  logic [sprc_pkg::ForceInputs-1:0][sprc_pkg::ForceW-1:0] force_i,
  input  logic [sprc_pkg::PressW-1:0]                            press_i,
  output logic [sprc_pkg::ForceW-1:0]                            peak_o,
  output logic [sprc_pkg::PressW-1:0]                            press_o
);
  import sprc_pkg::*;

  // Scan the active channels for the largest sample
  always_comb begin
    peak_o = '0;
    for (int i = 0; i < ForceInputs; i++) begin
      if (i < ForceChannels && force_i[i] > peak_o) begin
        peak_o = force_i[i];
      end
    end
  end

  // Clamp the pressure into the sensor window
  always_comb begin
    if (press_i < PressLo) begin
      press_o = PressLo;
    end else if (press_i > PressHi) begin
      press_o = PressHi;
    end else begin
      press_o = press_i;
    end
  end

endmodule

[sv/sprc_ctrl.sv]
// ----------------------------------------------------------------------------
// sprc_ctrl: sitting counter, mode choice and actuator control
// Holds the per-tick state and computes one result from a peak force and a
// clamped pressure. State advances only on a tick enable.
// ----------------------------------------------------------------------------
module sprc_ctrl #(
  parameter int unsigned SitCountBits  = sprc_pkg::DefSitCountBits,
  parameter int unsigned TicksPerMinute = sprc_pkg::DefTicksPerMinute
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  sprc_pkg::cfg_t              cfg_i,
  input  logic [sprc_pkg::ForceW-1:0] peak_i,
  input  logic [sprc_pkg::PressW-1:0] press_i,
  output sprc_pkg::res_t              res_o
);
  import sprc_pkg::*;

  localparam int unsigned RemW = (TicksPerMinute > 1) ? $clog2(TicksPerMinute) : 1;
  localparam int unsigned CmpW = (SitCountBits > TicksCfgW) ? SitCountBits : TicksCfgW;
  localparam logic [SitCountBits-1:0] CountMax = {SitCountBits{1'b1}};
  localparam logic [RemW-1:0] RemLast = RemW'(TicksPerMinute - 1);

  mode_e                   mode_q, mode_d;
  logic                    seated_q, seated_d;
  logic [SitCountBits-1:0] count_q, count_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [SitCountBits-1:0] minutes_q, minutes_d;
  logic                    step_q, step_d;
  logic [RelTimerW-1:0]    rtimer_q, rtimer_d;
  logic [BlinkW-1:0]       btimer_q, btimer_d;
  logic                    bphase_q, bphase_d;
  logic                    pump_q, pump_d;
  logic                    sitting;
  logic                    valve;
  logic                    buzz;
  logic                    phase;

  // Sitting count with a running minute count beside it
  always_comb begin
    sitting   = (peak_i >= cfg_i.sit_limit);
    seated_d  = seated_q;
    count_d   = count_q;
    rem_d     = rem_q;
    minutes_d = minutes_q;
    if (!sitting) begin
      seated_d  = 1'b0;
      count_d   = '0;
      rem_d     = '0;
      minutes_d = '0;
    end else if (!seated_q) begin
      seated_d  = 1'b1;
      count_d   = '0;
      rem_d     = '0;
      minutes_d = '0;
    end else if (count_q != CountMax) begin
      count_d = count_q + 1'b1;
      if (rem_q == RemLast) begin
        rem_d     = '0;
        minutes_d = minutes_q + 1'b1;
      end else begin
        rem_d = rem_q + 1'b1;
      end
    end
  end

  // Pick the mode from the peak and the updated count
  always_comb begin
    if (peak_i < cfg_i.idle_limit) begin
      mode_d = ModeIdle;
    end else if (sitting && CmpW'(count_d) >= CmpW'(cfg_i.danger_ticks)) begin
      mode_d = ModeDanger;
    end else if (sitting && CmpW'(count_d) >= CmpW'(cfg_i.warn_ticks)) begin
      mode_d = ModeWarning;
    end else begin
      mode_d = ModeNormal;
    end
  end

  // Blink, pump hysteresis and the vent and refill cycle
  always_comb begin
    logic [RelTimerW-1:0] rt;
    logic                 st;
    rt       = rtimer_q;
    st       = step_q;
    btimer_d = (btimer_q >= BlinkTicks) ? BlinkTicks : btimer_q + 1'b1;
    bphase_d = bphase_q;
    pump_d   = pump_q;
    valve    = 1'b0;
    buzz     = 1'b0;
    phase    = 1'b0;

    // Restart the relief cycle on entry to danger
    if (mode_d == ModeDanger) begin
      if (mode_q != ModeDanger) begin
        st = 1'b0;
        rt = '0;
      end else begin
        rt = (rt >= TimerMax) ? TimerMax : rt + 1'b1;
      end
    end

    if (mode_d == ModeWarning && btimer_d >= BlinkTicks) begin
      bphase_d = ~bphase_q;
      btimer_d = '0;
    end

    step_d   = st;
    rtimer_d = rt;
    case (mode_d)
      ModeWarning: begin
        if (press_i < cfg_i.pump_on_below) begin
          pump_d = 1'b1;
        end else if (press_i >= cfg_i.pump_off_at) begin
          pump_d = 1'b0;
        end
        buzz = bphase_d;
      end
      ModeDanger: begin
        buzz  = 1'b1;
        phase = st;
        if (!st) begin
          valve  = 1'b1;
          pump_d = 1'b0;
          if (rt >= VentTimeoutTicks || press_i <= cfg_i.vent_done_at) begin
            step_d   = 1'b1;
            rtimer_d = '0;
          end
        end else begin
          pump_d = 1'b1;
          if (press_i >= cfg_i.refill_done_at) begin
            step_d   = 1'b0;
            rtimer_d = '0;
          end
        end
      end
      default: begin
        pump_d = 1'b0;
      end
    endcase
  end

  // Assemble the result of this tick
  always_comb begin
    res_o.mode         = mode_d;
    res_o.pump_on      = pump_d;
    res_o.valve_open   = valve;
    res_o.buzzer_on    = buzz;
    res_o.peak_force   = peak_i;
    res_o.sit_minutes  = minutes_d[MinutesW-1:0];
    res_o.relief_phase = phase;
  end

  // Hold state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      seated_q  <= 1'b0;
      count_q   <= '0;
      rem_q     <= '0;
      minutes_q <= '0;
      step_q    <= 1'b0;
      rtimer_q  <= '0;
      btimer_q  <= BlinkTicks;
      bphase_q  <= 1'b0;
      pump_q    <= 1'b0;
    end else if (tick_i) begin
      mode_q    <= mode_d;
      seated_q  <= seated_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      minutes_q <= minutes_d;
      step_q    <= step_d;
      rtimer_q  <= rtimer_d;
      btimer_q  <= btimer_d;
      bphase_q  <= bphase_d;
      pump_q    <= pump_d;
    end
  end

endmodule

[sv/seat_pressure_relief_controller.sv]
// ----------------------------------------------------------------------------
// seat_pressure_relief_controller: cushion pressure relief top level
// Input register, per-tick control logic and result register, plus the
// configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction is one sensor tick: six force samples and one air
//   pressure sample. Each tick gives exactly one result transaction with the
//   mode, pump, valve and buzzer drives, the peak force, the sitting minutes
//   and the relief phase.
//   A tick is registered in the input register, passes once through the
//   control logic and lands in the result register; one tick can be taken
//   every cycle while out_stall_i does not hold the result register.
//   When the receiver asserts out_stall_i the result register holds; the
//   input register still takes one more transaction if it is empty, after
//   which in_stall_o rises until the result moves on.
//   Configuration writes are taken every cycle (cfg_ready_o stays high) and
//   should only be issued while no tick is in flight.
//   Reset clears the pipeline, loads the register defaults and returns the
//   controller to idle with the pump off and the blink timer saturated.
// ----------------------------------------------------------------------------
module seat_pressure_relief_controller #(
  parameter int unsigned SitCountBits   = sprc_pkg::DefSitCountBits,
  parameter int unsigned TicksPerMinute = sprc_pkg::DefTicksPerMinute
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Tick input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sprc_pkg::ForceW-1:0]    force_a_i,
  input  logic [sprc_pkg::ForceW-1:0]    force_b_i,
  input  logic [sprc_pkg::ForceW-1:0]    force_c_i,
  input  logic [sprc_pkg::ForceW-1:0]    force_d_i,
  input  logic [sprc_pkg::ForceW-1:0]    force_e_i,
  input  logic [sprc_pkg::ForceW-1:0]    force_f_i,
  input  logic [sprc_pkg::PressW-1:0]    air_pressure_i,
  // Result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     mode_o,
  output logic                           pump_on_o,
  output logic                           valve_open_o,
  output logic                           buzzer_on_o,
  output logic [sprc_pkg::ForceW-1:0]    peak_force_o,
  output logic [sprc_pkg::MinutesW-1:0]  sit_minutes_o,
  output logic                           relief_phase_o,
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [2:0]                     cfg_index_i,
  input  logic [sprc_pkg::TicksCfgW-1:0] cfg_data_i
);
  import sprc_pkg::*;

  logic                                in_valid_q;
  logic [ForceInputs-1:0][ForceW-1:0]  force_q;
  logic [PressW-1:0]                   press_q;
  logic                                out_valid_q;
  res_t                                res_q;
  res_t                                res;
  cfg_t                                cfg_q;
  logic [ForceW-1:0]                   peak;
  logic [PressW-1:0]                   press_clamped;
  logic                                advance;
  logic                                in_accept;
  logic                                tick;

  // Pipeline handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign tick       = advance && in_valid_q;

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      force_q <= {force_f_i, force_e_i, force_d_i, force_c_i, force_b_i, force_a_i};
      press_q <= air_pressure_i;
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_limit     <= RstIdleLimit;
      cfg_q.sit_limit      <= RstSitLimit;
      cfg_q.warn_ticks     <= RstWarnTicks;
      cfg_q.danger_ticks   <= RstDangerTicks;
      cfg_q.pump_on_below  <= RstPumpOnBelow;
      cfg_q.pump_off_at    <= RstPumpOffAt;
      cfg_q.vent_done_at   <= RstVentDoneAt;
      cfg_q.refill_done_at <= RstRefillDoneAt;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        RegIdleLimit:    cfg_q.idle_limit     <= cfg_data_i[ForceW-1:0];
        RegSitLimit:     cfg_q.sit_limit      <= cfg_data_i[ForceW-1:0];
        RegWarnTicks:    cfg_q.warn_ticks     <= cfg_data_i;
        RegDangerTicks:  cfg_q.danger_ticks   <= cfg_data_i;
        RegPumpOnBelow:  cfg_q.pump_on_below  <= cfg_data_i[PressW-1:0];
        RegPumpOffAt:    cfg_q.pump_off_at    <= cfg_data_i[PressW-1:0];
        RegVentDoneAt:   cfg_q.vent_done_at   <= cfg_data_i[PressW-1:0];
        RegRefillDoneAt: cfg_q.refill_done_at <= cfg_data_i[PressW-1:0];
        default: begin
        end
      endcase
    end
  end

  sprc_sample u_sample (
    .force_i (force_q),
    .press_i (press_q),
    .peak_o  (peak),
    .press_o (press_clamped)
  );

  sprc_ctrl #(
    .SitCountBits   (SitCountBits),
    .TicksPerMinute (TicksPerMinute)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .cfg_i   (cfg_q),
    .peak_i  (peak),
    .press_i (press_clamped),
    .res_o   (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_o         = res_q.mode;
  assign pump_on_o      = res_q.pump_on;
  assign valve_open_o   = res_q.valve_open;
  assign buzzer_on_o    = res_q.buzzer_on;
  assign peak_force_o   = res_q.peak_force;
  assign sit_minutes_o  = res_q.sit_minutes;
  assign relief_phase_o = res_q.relief_phase;

endmodule
